@@ rtl/core/swsnd_pkg.sv @@
// Package for the sliding window sender: widths, config register indexes,
// timer action codes, configuration defaults and the per-item result struct.
// No dependencies.
package swsnd_pkg;

    localparam int OFFSET_WIDTH_DEF = 16;
    localparam int FIELD_W          = 16;
    localparam int CFG_INDEX_W      = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MESSAGE_LENGTH      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_BYTES        = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEGMENT_PAYLOAD_MAX = 2'd2;

    localparam logic [FIELD_W-1:0] MESSAGE_LENGTH_RST      = 16'd0;
    localparam logic [FIELD_W-1:0] WINDOW_BYTES_RST        = 16'd4032;
    localparam logic [FIELD_W-1:0] SEGMENT_PAYLOAD_MAX_RST = 16'd1008;

    typedef enum logic [1:0] {
        TA_NONE  = 2'd0,
        TA_START = 2'd1,
        TA_STOP  = 2'd2
    } timer_action_t;

    typedef struct packed {
        logic                send_valid;
        logic                retransmit;
        logic [FIELD_W-1:0]  send_offset;
        logic [FIELD_W-1:0]  send_length;
        logic [FIELD_W-1:0]  send_ack;
        timer_action_t       timer_action;
        logic                done_res;
    } result_t;

endpackage

@@ rtl/core/sliding_window_sender_top.sv @@
// Sliding window sender top level: stream ports, input and output registers,
// configuration registers. Depends on swsnd_pkg and swsnd_step.
//
//  channel   dir   handshake                     payload
//  s_axis    in    s_axis_tvalid/s_axis_tready   tdata, tuser (one loop event)
//  m_axis    out   m_axis_tvalid/m_axis_tready   tdata, tuser (one result)
//  config    in    wr_en                         wr_index, wr_data
//
// One transaction in, one out. Events pass the input register, then the
// window update writes state and the output register together. The state
// loop (compare, length, add, ack compare) is combinational. Reset clears
// the window state, the valid flags and loads the default config. A stalled
// output holds both registers; the input side takes a new event every cycle
// while the output register is free or being taken.
module sliding_window_sender_top #(
    parameter int OFFSET_WIDTH = swsnd_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] timer_expired, [16:1] ack_number, [32:17] piggyback_ack
    input  logic [39:0]                       s_axis_tdata,
    // [0] ack_present
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] send_offset, [31:16] send_length, [47:32] send_ack,
    // [49:48] timer_action, [50] done_res
    output logic [55:0]                       m_axis_tdata,
    // [0] send_valid, [1] retransmit
    output logic [1:0]                        m_axis_tuser,
    input  logic                              wr_en,
    input  logic [swsnd_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [swsnd_pkg::FIELD_W-1:0]     wr_data
);

    logic [swsnd_pkg::FIELD_W-1:0] msg_len_reg;
    logic [swsnd_pkg::FIELD_W-1:0] window_reg;
    logic [swsnd_pkg::FIELD_W-1:0] seg_max_reg;

    logic                          in_valid_reg;
    logic                          in_expired_reg;
    logic                          in_ack_present_reg;
    logic [swsnd_pkg::FIELD_W-1:0] in_ack_reg;
    logic [swsnd_pkg::FIELD_W-1:0] in_pig_reg;

    logic                          out_valid_reg;
    swsnd_pkg::result_t            out_reg;
    swsnd_pkg::result_t            result;

    logic advance;
    logic in_take;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_len_reg <= swsnd_pkg::MESSAGE_LENGTH_RST;
            window_reg  <= swsnd_pkg::WINDOW_BYTES_RST;
            seg_max_reg <= swsnd_pkg::SEGMENT_PAYLOAD_MAX_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                swsnd_pkg::CFG_MESSAGE_LENGTH:      msg_len_reg <= wr_data;
                swsnd_pkg::CFG_WINDOW_BYTES:        window_reg  <= wr_data;
                swsnd_pkg::CFG_SEGMENT_PAYLOAD_MAX: seg_max_reg <= wr_data;
                default:                            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_expired_reg     <= s_axis_tdata[0];
            in_ack_reg         <= s_axis_tdata[16:1];
            in_pig_reg         <= s_axis_tdata[32:17];
            in_ack_present_reg <= s_axis_tuser[0];
        end
        if (advance && in_valid_reg)
        begin
            out_reg <= result;
        end
    end

    swsnd_step #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_step (
        .clk                 (clk),
        .rst_n               (rst_n),
        .step_en             (advance && in_valid_reg),
        .timer_expired       (in_expired_reg),
        .ack_present         (in_ack_present_reg),
        .ack_number          (in_ack_reg),
        .piggyback_ack       (in_pig_reg),
        .message_length      (msg_len_reg),
        .window_bytes        (window_reg),
        .segment_payload_max (seg_max_reg),
        .result              (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0,
                            out_reg.done_res,
                            out_reg.timer_action,
                            out_reg.send_ack,
                            out_reg.send_length,
                            out_reg.send_offset};
    assign m_axis_tuser  = {out_reg.retransmit, out_reg.send_valid};

endmodule

@@ rtl/core/swsnd_step.sv @@
// Window state (next sequence, send base, oldest unacked, timer flag) and the
// per-item update logic: resend / new send decision, then ack processing.
// Depends on swsnd_pkg.
module swsnd_step #(
    parameter int OFFSET_WIDTH = swsnd_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  logic                          timer_expired,
    input  logic                          ack_present,
    input  logic [swsnd_pkg::FIELD_W-1:0] ack_number,
    input  logic [swsnd_pkg::FIELD_W-1:0] piggyback_ack,
    input  logic [swsnd_pkg::FIELD_W-1:0] message_length,
    input  logic [swsnd_pkg::FIELD_W-1:0] window_bytes,
    input  logic [swsnd_pkg::FIELD_W-1:0] segment_payload_max,
    output swsnd_pkg::result_t            result
);

    // compare width: wide enough for offsets, 16-bit fields and base + window
    localparam int WW = ((OFFSET_WIDTH > swsnd_pkg::FIELD_W) ?
                         OFFSET_WIDTH : swsnd_pkg::FIELD_W) + 1;

    logic [OFFSET_WIDTH-1:0] next_seq_reg,  next_seq_next;
    logic [OFFSET_WIDTH-1:0] send_base_reg, send_base_next;
    logic [OFFSET_WIDTH-1:0] oldest_reg,    oldest_next;
    logic                    timer_reg,     timer_next;

    logic [WW-1:0]                  msg_ext;
    logic [WW-1:0]                  base_ext;
    logic [WW-1:0]                  seq_ext;
    logic [WW-1:0]                  ack_ext;
    logic [WW-1:0]                  off_ext;
    logic [WW-1:0]                  rem_ext;
    logic [WW-1:0]                  seq_after_ext;
    logic [WW-1:0]                  base_new_ext;
    logic                           active;
    logic                           exp_hit;
    logic                           new_ok;
    logic                           send;
    logic                           ack_ok;
    logic [OFFSET_WIDTH-1:0]        off;
    logic [swsnd_pkg::FIELD_W-1:0]  len;
    logic [OFFSET_WIDTH-1:0]        seq_after;
    logic [OFFSET_WIDTH-1:0]        base_new;
    swsnd_pkg::timer_action_t       action;

    always_comb
    begin
        msg_ext  = WW'(message_length);
        base_ext = WW'(send_base_reg);
        seq_ext  = WW'(next_seq_reg);
        ack_ext  = WW'(ack_number);

        active  = base_ext < msg_ext;
        exp_hit = timer_expired && timer_reg;
        new_ok  = (seq_ext < msg_ext) &&
                  (seq_ext < (base_ext + WW'(window_bytes)));
        send    = active && (exp_hit || new_ok);

        // segment length taken at the offset actually sent
        off     = exp_hit ? oldest_reg : next_seq_reg;
        off_ext = WW'(off);
        rem_ext = msg_ext - off_ext;
        if (off_ext >= msg_ext)
        begin
            len = '0;
        end
        else if (rem_ext > WW'(segment_payload_max))
        begin
            len = segment_payload_max;
        end
        else
        begin
            len = swsnd_pkg::FIELD_W'(rem_ext);
        end

        timer_next  = timer_reg;
        oldest_next = oldest_reg;
        action      = swsnd_pkg::TA_NONE;
        seq_after   = next_seq_reg;

        if (active && exp_hit)
        begin
            timer_next = 1'b1;
            action     = swsnd_pkg::TA_START;
        end
        else if (active && new_ok)
        begin
            if (!timer_reg)
            begin
                timer_next  = 1'b1;
                action      = swsnd_pkg::TA_START;
                oldest_next = send_base_reg;
            end
            seq_after = OFFSET_WIDTH'(seq_ext + WW'(len));
        end

        // acks past what has been sent are dropped
        seq_after_ext = WW'(seq_after);
        ack_ok        = active && ack_present && (ack_ext <= seq_after_ext);
        base_new      = send_base_reg;
        if (ack_ok && (ack_ext > base_ext))
        begin
            base_new = OFFSET_WIDTH'(ack_number);
        end
        if (ack_ok)
        begin
            if (base_new == seq_after)
            begin
                timer_next = 1'b0;
                action     = swsnd_pkg::TA_STOP;
            end
            else
            begin
                timer_next = 1'b1;
                action     = swsnd_pkg::TA_START;
            end
            oldest_next = base_new;
        end

        next_seq_next  = seq_after;
        send_base_next = base_new;
        base_new_ext   = WW'(base_new);
    end

    always_comb
    begin
        result.send_valid   = send;
        result.retransmit   = active && exp_hit;
        result.send_offset  = send ? swsnd_pkg::FIELD_W'(off) : '0;
        result.send_length  = send ? len : '0;
        result.send_ack     = send ? piggyback_ack : '0;
        result.timer_action = action;
        result.done_res     = base_new_ext >= msg_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_seq_reg  <= '0;
            send_base_reg <= '0;
            oldest_reg    <= '0;
            timer_reg     <= 1'b0;
        end
        else if (step_en)
        begin
            next_seq_reg  <= next_seq_next;
            send_base_reg <= send_base_next;
            oldest_reg    <= oldest_next;
            timer_reg     <= timer_next;
        end
    end

endmodule
